### design/acc_pkg.sv
package acc_pkg;

  localparam int SYM_W = 8;   // character byte
  localparam int IDX_W = 6;   // table position carried by a load beat
  localparam int LEN_W = 7;   // alphabet length and every residue below it
  localparam int KEY_W = 8;   // multiplier and offset keys
  localparam int REG_W = 2;   // configuration register index

  localparam logic [1:0] OP_ENCRYPT = 2'd0;
  localparam logic [1:0] OP_DECRYPT = 2'd1;
  localparam logic [1:0] OP_LOAD    = 2'd2;

  localparam logic [REG_W-1:0] REG_KEY_MULTIPLIER  = 2'd0;
  localparam logic [REG_W-1:0] REG_KEY_OFFSET      = 2'd1;
  localparam logic [REG_W-1:0] REG_ALPHABET_LENGTH = 2'd2;

  typedef struct packed {
    logic [1:0]       operation;
    logic [SYM_W-1:0] symbol;
    logic [IDX_W-1:0] table_index;
  } in_beat_t;

  typedef struct packed {
    logic [SYM_W-1:0] symbol_out;
    logic             in_alphabet;
    logic             key_invertible;
  } out_beat_t;

  // Derived key material handed from the key unit to the sequencer
  typedef struct packed {
    logic [LEN_W-1:0] m;       // effective alphabet length
    logic [LEN_W-1:0] a_m;     // a mod m
    logic [LEN_W-1:0] b_m;     // b mod m
    logic [LEN_W-1:0] inv;     // a^-1 mod m, zero if none
    logic [LEN_W-1:0] d0;      // (-b * a^-1) mod m
    logic             ok;      // gcd(a, m) == 1
    logic             busy;    // recomputing after a register write
  } key_info_t;

  // (x + y) mod m for x, y already below m
  function automatic logic [LEN_W-1:0] add_mod(input logic [LEN_W-1:0] x,
                                               input logic [LEN_W-1:0] y,
                                               input logic [LEN_W-1:0] m);
    logic [LEN_W:0] s;
    s = {1'b0, x} + {1'b0, y};
    if (s >= {1'b0, m}) begin
      s = s - {1'b0, m};
    end
    return s[LEN_W-1:0];
  endfunction

endpackage

### design/affine_cipher_char_unit.sv
// Affine cipher on one character per beat over a loadable alphabet held in a
// rotating ring of DEPTH cells. Load beats (operation 2) write one symbol at a
// table position; encrypt beats map table position j to (j*a+b) mod m and
// decrypt beats to ((j-b) mod m)*a^-1 mod m, where j is the first position
// below m whose entry equals the symbol and m is alphabet_length capped at
// DEPTH. Symbols not in the alphabet, and decrypts under a key that has no
// inverse, come back unchanged. Every result carries in_alphabet and
// key_invertible. Timing: the ring turns one cell per cycle and the head cell
// is the only one looked at, so a load waits for its slot to reach the head;
// an encrypt or decrypt waits for entry 0, scans up to m entries, then waits
// for the target entry to reach the head, and the result is loaded into the
// output register once that register is free; the next beat is taken after
// the result is in that register. One beat is in flight at a
// time; a finished result sits in the output register while the next beat is
// taken. A configuration write starts a key recompute (a setup step, 8
// reduction steps, up to m inverse steps, up to m offset steps) during which
// in_ready is low. Table entries are not cleared by reset and must be loaded
// before the alphabet is used.
module affine_cipher_char_unit #(
  parameter int DEPTH = 64
) (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      in_valid,
  output logic                      in_ready,
  input  acc_pkg::in_beat_t         in_data,
  output logic                      out_valid,
  input  logic                      out_ready,
  output acc_pkg::out_beat_t        out_data,
  input  logic                      cfg_wr_en,
  input  logic [acc_pkg::REG_W-1:0] cfg_index,
  input  logic [acc_pkg::KEY_W-1:0] cfg_data
);
  import acc_pkg::*;

  localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = (PW > LEN_W) ? PW : LEN_W;   // common compare width

  typedef enum logic [2:0] {S_IDLE, S_LOAD, S_SCAN, S_READ, S_EMIT} st_t;

  st_t              st_r;
  logic [1:0]       op_r;
  logic [SYM_W-1:0] sym_r, res_r;
  logic [IDX_W-1:0] idx_r;
  logic             started_r, found_r;
  logic [LEN_W-1:0] enc_r, dec_r, target_r;
  logic             out_valid_r;
  out_beat_t        out_data_r;

  key_info_t        keys;
  logic [SYM_W-1:0] head;
  logic [PW-1:0]    pos;
  logic [CW-1:0]    pos_c, m_c;
  logic             in_fire, scan_act, ring_wr, slot_free;

  acc_keys #(.DEPTH(DEPTH)) u_keys (
    .clk      (clk),
    .rst_n    (rst_n),
    .cfg_wr_en(cfg_wr_en),
    .cfg_index(cfg_index),
    .cfg_data (cfg_data),
    .keys     (keys)
  );

  acc_ring #(.DEPTH(DEPTH), .PW(PW)) u_ring (
    .clk    (clk),
    .rst_n  (rst_n),
    .wr_en  (ring_wr),
    .wr_data(sym_r),
    .head   (head),
    .pos    (pos)
  );

  assign pos_c     = CW'(pos);
  assign m_c       = CW'(keys.m);
  assign in_ready  = (st_r == S_IDLE) && !keys.busy && !cfg_wr_en;
  assign in_fire   = in_valid && in_ready;
  // the search starts when entry 0 reaches the head
  assign scan_act  = (st_r == S_SCAN) && (started_r || pos == '0);
  assign ring_wr   = (st_r == S_LOAD) && (pos_c == CW'(idx_r));
  assign slot_free = !out_valid_r || out_ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r        <= S_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      // S_EMIT refills the slot itself whenever it is freed
      if (out_valid_r && out_ready && st_r != S_EMIT) out_valid_r <= 1'b0;

      unique case (st_r)
        S_IDLE: begin
          if (in_fire) begin
            op_r      <= in_data.operation;
            sym_r     <= in_data.symbol;
            idx_r     <= in_data.table_index;
            res_r     <= in_data.symbol;     // pass-through unless remapped
            found_r   <= 1'b0;
            started_r <= 1'b0;
            enc_r     <= keys.b_m;
            dec_r     <= keys.d0;
            if (in_data.operation == OP_ENCRYPT || in_data.operation == OP_DECRYPT) begin
              st_r <= S_SCAN;
            end else if (in_data.operation == OP_LOAD &&
                         32'(in_data.table_index) < DEPTH) begin
              st_r <= S_LOAD;
            end else begin
              st_r <= S_EMIT;
            end
          end
        end
        S_LOAD: begin
          if (ring_wr) st_r <= S_EMIT;
        end
        S_SCAN: begin
          if (scan_act) begin
            started_r <= 1'b1;
            if (pos_c >= m_c) begin
              st_r <= S_EMIT;                // empty alphabet
            end else if (head == sym_r) begin
              found_r <= 1'b1;
              if (op_r == OP_DECRYPT && !keys.ok) begin
                st_r <= S_EMIT;
              end else begin
                target_r <= (op_r == OP_DECRYPT) ? dec_r : enc_r;
                st_r     <= S_READ;
              end
            end else if (pos_c == m_c - 1'b1) begin
              st_r <= S_EMIT;                // not in alphabet
            end else begin
              enc_r <= add_mod(enc_r, keys.a_m, keys.m);
              dec_r <= add_mod(dec_r, keys.inv, keys.m);
            end
          end
        end
        S_READ: begin
          if (pos_c == CW'(target_r)) begin
            res_r <= head;
            st_r  <= S_EMIT;
          end
        end
        S_EMIT: begin
          if (slot_free) begin
            out_valid_r <= 1'b1;
            out_data_r  <= '{symbol_out: res_r, in_alphabet: found_r,
                             key_invertible: keys.ok};
            st_r        <= S_IDLE;
          end
        end
        default: st_r <= S_IDLE;
      endcase
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  a_ready_keys: assert property (@(posedge clk) disable iff (!rst_n)
    in_ready |-> !keys.busy)
    else $error("beat taken during key recompute");

  a_fire_busy: assert property (@(posedge clk) disable iff (!rst_n)
    in_fire |=> st_r != S_IDLE)
    else $error("accepted beat not in progress");

  a_read_found: assert property (@(posedge clk) disable iff (!rst_n)
    st_r == S_READ |-> found_r && (target_r < keys.m))
    else $error("table read without a match or beyond length");

  a_emit_out: assert property (@(posedge clk) disable iff (!rst_n)
    (st_r == S_EMIT && slot_free) |=> out_valid_r && st_r == S_IDLE)
    else $error("result not delivered to output register");

  a_write_load: assert property (@(posedge clk) disable iff (!rst_n)
    ring_wr |-> op_r == OP_LOAD)
    else $error("table written outside a load beat");

endmodule

### design/acc_cell.sv
module acc_cell (
  input  logic                      clk,
  input  logic [acc_pkg::SYM_W-1:0] nb_in,
  input  logic                      ld,
  input  logic [acc_pkg::SYM_W-1:0] ld_data,
  output logic [acc_pkg::SYM_W-1:0] q
);
  import acc_pkg::*;

  logic [SYM_W-1:0] q_r;

  // takes the neighbour's entry every cycle, or a new symbol when loaded
  always_ff @(posedge clk) begin
    q_r <= ld ? ld_data : nb_in;
  end

  assign q = q_r;

endmodule

### design/acc_ring.sv
module acc_ring #(
  parameter int DEPTH = 64,
  parameter int PW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      wr_en,
  input  logic [acc_pkg::SYM_W-1:0] wr_data,
  output logic [acc_pkg::SYM_W-1:0] head,
  output logic [PW-1:0]             pos
);
  import acc_pkg::*;

  logic [SYM_W-1:0] cell_q [DEPTH];
  logic [PW-1:0]    pos_r;

  // Ring rotates left every cycle; cell 0 holds logical entry pos_r.
  // A write replaces the head entry as it wraps into the tail cell.
  for (genvar i = 0; i < DEPTH; i++) begin : g_cell
    if (i == DEPTH - 1) begin : g_tail
      acc_cell u_cell (
        .clk    (clk),
        .nb_in  (cell_q[0]),
        .ld     (wr_en),
        .ld_data(wr_data),
        .q      (cell_q[i])
      );
    end else begin : g_body
      acc_cell u_cell (
        .clk    (clk),
        .nb_in  (cell_q[i+1]),
        .ld     (1'b0),
        .ld_data(wr_data),
        .q      (cell_q[i])
      );
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pos_r <= '0;
    end else if (pos_r == PW'(DEPTH - 1)) begin
      pos_r <= '0;
    end else begin
      pos_r <= pos_r + 1'b1;
    end
  end

  assign head = cell_q[0];
  assign pos  = pos_r;

endmodule

### design/acc_keys.sv
module acc_keys #(
  parameter int DEPTH = 64
) (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      cfg_wr_en,
  input  logic [acc_pkg::REG_W-1:0] cfg_index,
  input  logic [acc_pkg::KEY_W-1:0] cfg_data,
  output acc_pkg::key_info_t        keys
);
  import acc_pkg::*;

  typedef enum logic [2:0] {K_IDLE, K_LOAD, K_MOD, K_INV, K_OFF} kst_t;

  localparam logic [LEN_W-1:0] DEPTH_CAP = (DEPTH > 127) ? LEN_W'(127) : LEN_W'(DEPTH);
  localparam int SH_W = KEY_W + LEN_W;

  kst_t             st_r;
  logic [KEY_W-1:0] key_a_r, key_b_r;
  logic [LEN_W-1:0] len_r;
  logic [KEY_W-1:0] rem_a_r, rem_b_r;
  logic [2:0]       step_r;
  logic [LEN_W-1:0] x_r, r_r, cnt_r, acc_r;
  logic [LEN_W-1:0] a_m_r, b_m_r, inv_r, d0_r;
  logic             ok_r;

  logic [LEN_W-1:0] m;
  logic [SH_W-1:0]  m_sh;
  logic [LEN_W-1:0] one_m;

  assign m     = (32'(len_r) > DEPTH) ? DEPTH_CAP : len_r;
  assign m_sh  = SH_W'(m) << step_r;
  assign one_m = (m == LEN_W'(1)) ? '0 : LEN_W'(1);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r    <= K_IDLE;
      key_a_r <= KEY_W'(1);
      key_b_r <= '0;
      len_r   <= LEN_W'(26);
      a_m_r   <= LEN_W'(1);
      b_m_r   <= '0;
      inv_r   <= LEN_W'(1);
      d0_r    <= '0;
      ok_r    <= 1'b1;
    end else if (cfg_wr_en && (cfg_index == REG_KEY_MULTIPLIER ||
                               cfg_index == REG_KEY_OFFSET ||
                               cfg_index == REG_ALPHABET_LENGTH)) begin
      unique case (cfg_index)
        REG_KEY_MULTIPLIER: key_a_r <= cfg_data;
        REG_KEY_OFFSET:     key_b_r <= cfg_data;
        default:            len_r   <= cfg_data[LEN_W-1:0];
      endcase
      st_r <= K_LOAD;
    end else begin
      unique case (st_r)
        K_IDLE: ;
        K_LOAD: begin
          rem_a_r <= key_a_r;
          rem_b_r <= key_b_r;
          step_r  <= 3'd7;
          inv_r   <= '0;
          d0_r    <= '0;
          ok_r    <= 1'b0;
          st_r    <= (m == '0) ? K_IDLE : K_MOD;
        end
        K_MOD: begin
          // restoring reduction, one quotient bit a cycle
          if (SH_W'(rem_a_r) >= m_sh) rem_a_r <= rem_a_r - m_sh[KEY_W-1:0];
          if (SH_W'(rem_b_r) >= m_sh) rem_b_r <= rem_b_r - m_sh[KEY_W-1:0];
          step_r <= step_r - 1'b1;
          if (step_r == '0) begin
            x_r  <= '0;
            r_r  <= '0;
            st_r <= K_INV;
          end
        end
        K_INV: begin
          a_m_r <= rem_a_r[LEN_W-1:0];
          b_m_r <= rem_b_r[LEN_W-1:0];
          // r_r tracks x * a mod m
          if (r_r == one_m) begin
            inv_r <= x_r;
            ok_r  <= 1'b1;
            cnt_r <= '0;
            acc_r <= '0;
            st_r  <= K_OFF;
          end else if (x_r == m - 1'b1) begin
            st_r <= K_IDLE;
          end else begin
            r_r <= add_mod(r_r, rem_a_r[LEN_W-1:0], m);
            x_r <= x_r + 1'b1;
          end
        end
        K_OFF: begin
          // acc = b * inv mod m by repeated addition
          if (cnt_r == b_m_r) begin
            d0_r <= (acc_r == '0) ? '0 : m - acc_r;
            st_r <= K_IDLE;
          end else begin
            acc_r <= add_mod(acc_r, inv_r, m);
            cnt_r <= cnt_r + 1'b1;
          end
        end
        default: st_r <= K_IDLE;
      endcase
    end
  end

  assign keys = '{m: m, a_m: a_m_r, b_m: b_m_r, inv: inv_r, d0: d0_r,
                  ok: ok_r, busy: (st_r != K_IDLE)};

endmodule
